>>> src/tsc_pkg.sv
// Shared types and constants for the touch stroke capture block.
package tsc_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [15:0] FIRST_WINDOW_RESET  = 16'd2000;
    localparam logic [15:0] CAPTURE_LIMIT_RESET = 16'd5000;

    localparam logic [3:0] COUNT_MASK    = 4'hf;
    localparam logic [3:0] MAX_POINTS    = 4'd2;
    localparam logic [1:0] EVENT_LIFT    = 2'h1;
    localparam logic [1:0] RELEASE_LIMIT = 2'd3;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    localparam logic EV_POINT  = 1'b0;
    localparam logic EV_STROKE = 1'b1;

    localparam logic [0:0] REG_FIRST_WINDOW  = 1'd0;
    localparam logic [0:0] REG_CAPTURE_LIMIT = 1'd1;

    typedef struct packed {
        logic        kind;
        logic        read_ok;
        logic        pressed;
        logic [11:0] px;
        logic [11:0] py;
        logic [31:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic        event_res;
        logic [11:0] point_x;
        logic [11:0] point_y;
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [11:0] end_x;
        logic [11:0] end_y;
        logic        stroke_valid;
        logic [31:0] duration_ms;
    } res_t;

endpackage

>>> src/tsc_front.sv
// Input side: takes words, decodes the first touch point and queues a command.
module tsc_front
(
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic              read_ok,
    input  logic [7:0]        status_byte,
    input  logic [7:0]        x_high_byte,
    input  logic [7:0]        x_low_byte,
    input  logic [7:0]        y_high_byte,
    input  logic [7:0]        y_low_byte,
    input  logic [31:0]       now_ms,
    input  logic              queue_full,
    output logic              push,
    output tsc_pkg::cmd_t     push_cmd
);

    logic [3:0] count;
    logic       count_ok;
    logic       lifted;

    assign count    = status_byte[3:0] & tsc_pkg::COUNT_MASK;
    assign count_ok = (count != 4'd0) && (count <= tsc_pkg::MAX_POINTS);
    assign lifted   = (x_high_byte[7:6] == tsc_pkg::EVENT_LIFT);

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_cmd.kind    = kind;
        push_cmd.read_ok = read_ok;
        push_cmd.pressed = count_ok && !lifted;
        push_cmd.px      = {x_high_byte[3:0], x_low_byte};
        push_cmd.py      = {y_high_byte[3:0], y_low_byte};
        push_cmd.now_ms  = now_ms;
    end

endmodule

>>> src/tsc_fifo.sv
// Short command queue between the decode side and the stroke machine.
module tsc_fifo
#(
    parameter int DEPTH = tsc_pkg::FIFO_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tsc_pkg::cmd_t     push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output tsc_pkg::cmd_t     pop_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tsc_pkg::cmd_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/tsc_back.sv
// Stroke machine: consumes queued commands and holds the result word register.
module tsc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       first_window_ms,
    input  logic [15:0]       capture_limit_ms,
    input  logic              cmd_valid,
    input  tsc_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output tsc_pkg::res_t     out_res
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FIRST = 2'd1;
    localparam logic [1:0] PH_TRACK = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [31:0]   start_time_reg, start_time_next;
    logic [31:0]   first_time_reg, first_time_next;
    logic [11:0]   first_x_reg, first_x_next;
    logic [11:0]   first_y_reg, first_y_next;
    logic [11:0]   last_x_reg, last_x_next;
    logic [11:0]   last_y_reg, last_y_next;
    logic [1:0]    release_count_reg, release_count_next;
    logic          out_valid_reg, out_valid_next;
    tsc_pkg::res_t out_res_reg, out_res_next;

    logic [31:0]   elapsed;
    logic [31:0]   since_first;
    logic [1:0]    release_inc;
    logic          emit;
    logic          step;
    tsc_pkg::res_t res;

    assign step        = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_pop     = step;
    assign elapsed     = cmd.now_ms - start_time_reg;
    assign since_first = cmd.now_ms - first_time_reg;
    assign release_inc = release_count_reg + 2'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        start_time_next    = start_time_reg;
        first_time_next    = first_time_reg;
        first_x_next       = first_x_reg;
        first_y_next       = first_y_reg;
        last_x_next        = last_x_reg;
        last_y_next        = last_y_reg;
        release_count_next = release_count_reg;
        emit               = 1'b0;
        res                = '0;
        if (step)
        begin
            if (cmd.kind == tsc_pkg::KIND_START)
            begin
                phase_next         = PH_FIRST;
                start_time_next    = cmd.now_ms;
                first_time_next    = '0;
                first_x_next       = '0;
                first_y_next       = '0;
                last_x_next        = '0;
                last_y_next        = '0;
                release_count_next = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        if (elapsed >= {16'd0, first_window_ms})
                        begin
                            phase_next    = PH_IDLE;
                            emit          = 1'b1;
                            res.event_res = tsc_pkg::EV_STROKE;
                        end
                        else if (cmd.read_ok && cmd.pressed)
                        begin
                            first_x_next       = cmd.px;
                            first_y_next       = cmd.py;
                            last_x_next        = cmd.px;
                            last_y_next        = cmd.py;
                            first_time_next    = cmd.now_ms;
                            release_count_next = '0;
                            phase_next         = PH_TRACK;
                            emit               = 1'b1;
                            res.event_res      = tsc_pkg::EV_POINT;
                            res.point_x        = cmd.px;
                            res.point_y        = cmd.py;
                            res.start_x        = cmd.px;
                            res.start_y        = cmd.py;
                            res.end_x          = cmd.px;
                            res.end_y          = cmd.py;
                            res.stroke_valid   = 1'b1;
                        end
                    end
                    PH_TRACK:
                    begin
                        if (elapsed >= {16'd0, capture_limit_ms})
                        begin
                            phase_next       = PH_IDLE;
                            emit             = 1'b1;
                            res.event_res    = tsc_pkg::EV_STROKE;
                            res.start_x      = first_x_reg;
                            res.start_y      = first_y_reg;
                            res.end_x        = last_x_reg;
                            res.end_y        = last_y_reg;
                            res.stroke_valid = 1'b1;
                            res.duration_ms  = since_first;
                        end
                        else if (cmd.read_ok)
                        begin
                            if (cmd.pressed)
                            begin
                                last_x_next        = cmd.px;
                                last_y_next        = cmd.py;
                                release_count_next = '0;
                                emit               = 1'b1;
                                res.event_res      = tsc_pkg::EV_POINT;
                                res.point_x        = cmd.px;
                                res.point_y        = cmd.py;
                                res.start_x        = first_x_reg;
                                res.start_y        = first_y_reg;
                                res.end_x          = cmd.px;
                                res.end_y          = cmd.py;
                                res.stroke_valid   = 1'b1;
                            end
                            else if (release_inc >= tsc_pkg::RELEASE_LIMIT)
                            begin
                                phase_next         = PH_IDLE;
                                release_count_next = '0;
                                emit               = 1'b1;
                                res.event_res      = tsc_pkg::EV_STROKE;
                                res.start_x        = first_x_reg;
                                res.start_y        = first_y_reg;
                                res.end_x          = last_x_reg;
                                res.end_y          = last_y_reg;
                                res.stroke_valid   = 1'b1;
                                res.duration_ms    = since_first;
                            end
                            else
                            begin
                                release_count_next = release_inc;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (step && emit)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            start_time_reg    <= '0;
            first_time_reg    <= '0;
            first_x_reg       <= '0;
            first_y_reg       <= '0;
            last_x_reg        <= '0;
            last_y_reg        <= '0;
            release_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            start_time_reg    <= start_time_next;
            first_time_reg    <= first_time_next;
            first_x_reg       <= first_x_next;
            first_y_reg       <= first_y_next;
            last_x_reg        <= last_x_next;
            last_y_reg        <= last_y_next;
            release_count_reg <= release_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

>>> src/touch_stroke_capture_core.sv
// Top level of the touch stroke capture block: stream ports, register file, front and back.
//
// The block takes one word per clock on the slave stream (a capture start or a touch poll)
// while the command queue is not full, and gives at most one result word per word taken,
// in order. The stroke machine takes one queued word per cycle while its result register
// is empty or being taken. A taken word is written into the command queue; the stroke
// machine then loads any result word into the result register driving the master stream.
// A short command queue between decode and the stroke machine lets the input keep taking
// words while a result waits to be taken. Registers: first_window_ms at 0x0,
// capture_limit_ms at 0x4; write them only while no word is in flight.
module touch_stroke_capture_core
#(
    parameter int FIFO_DEPTH = tsc_pkg::FIFO_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] read_ok, [8:1] status_byte, [16:9] x_high_byte, [24:17] x_low_byte,
    // [32:25] y_high_byte, [40:33] y_low_byte, [72:41] now_ms, [79:73] zero
    input  logic [79:0]  s_tdata,
    // [0] kind
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [11:0] point_x, [23:12] point_y, [35:24] start_x, [47:36] start_y, [59:48] end_x,
    // [71:60] end_y, [72] stroke_valid, [104:73] duration_ms, [111:105] zero
    output logic [111:0] m_tdata,
    // [0] event_res
    output logic         m_tuser
);

    logic [15:0]   first_window_reg;
    logic [15:0]   capture_limit_reg;
    logic          cfg_write;

    logic          push;
    tsc_pkg::cmd_t push_cmd;
    logic          queue_full;
    logic          cmd_pop;
    logic          cmd_valid;
    tsc_pkg::cmd_t cmd;
    tsc_pkg::res_t res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_window_reg  <= tsc_pkg::FIRST_WINDOW_RESET;
            capture_limit_reg <= tsc_pkg::CAPTURE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == tsc_pkg::REG_FIRST_WINDOW)
            begin
                first_window_reg <= pwdata[15:0];
            end
            else
            begin
                capture_limit_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            tsc_pkg::REG_FIRST_WINDOW:  prdata = {16'd0, first_window_reg};
            tsc_pkg::REG_CAPTURE_LIMIT: prdata = {16'd0, capture_limit_reg};
            default:                    prdata = '0;
        endcase
    end

    tsc_front u_front
    (
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .kind        (s_tuser),
        .read_ok     (s_tdata[0]),
        .status_byte (s_tdata[8:1]),
        .x_high_byte (s_tdata[16:9]),
        .x_low_byte  (s_tdata[24:17]),
        .y_high_byte (s_tdata[32:25]),
        .y_low_byte  (s_tdata[40:33]),
        .now_ms      (s_tdata[72:41]),
        .queue_full  (queue_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    tsc_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .pop_cmd   (cmd)
    );

    tsc_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .first_window_ms  (first_window_reg),
        .capture_limit_ms (capture_limit_reg),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_pop          (cmd_pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_res          (res)
    );

    assign m_tuser = res.event_res;
    assign m_tdata = {7'd0, res.duration_ms, res.stroke_valid, res.end_y, res.end_x,
                      res.start_y, res.start_x, res.point_y, res.point_x};

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for touch_stroke_capture_core: directed and random stroke traffic.
module tb;

    localparam int HOLD_CYCLES = 80;

    typedef enum logic [1:0] {CAP_IDLE, CAP_WAIT_FIRST, CAP_TRACKING} cap_phase_t;

    typedef struct packed {
        logic        kind;
        logic        read_ok;
        logic [7:0]  status;
        logic [7:0]  x_high;
        logic [7:0]  x_low;
        logic [7:0]  y_high;
        logic [7:0]  y_low;
        logic [31:0] now_ms;
    } touch_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [111:0] m_tdata;
    logic         m_tuser;

    touch_stroke_capture_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // stroke machine mirror
    cap_phase_t  cap_phase = CAP_IDLE;
    logic [31:0] cap_start_ms = '0;
    logic [31:0] first_ms = '0;
    logic [11:0] first_x = '0;
    logic [11:0] first_y = '0;
    logic [11:0] last_x = '0;
    logic [11:0] last_y = '0;
    logic [1:0]  release_run = '0;
    logic [15:0] window_ms = tsc_pkg::FIRST_WINDOW_RESET;
    logic [15:0] limit_ms = tsc_pkg::CAPTURE_LIMIT_RESET;

    tsc_pkg::res_t stroke_q[$];
    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    logic [31:0] clock_ms = '0;
    bit          tx_gap_en = 1'b0;
    bit          rx_stall_en = 1'b0;
    bit          hold_req = 1'b0;

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    function automatic string show(input tsc_pkg::res_t r);
        return $sformatf("ev=%0d p=(%0d,%0d) s=(%0d,%0d) e=(%0d,%0d) v=%0d d=%0d",
                         r.event_res, r.point_x, r.point_y, r.start_x, r.start_y,
                         r.end_x, r.end_y, r.stroke_valid, r.duration_ms);
    endfunction

    function automatic logic [11:0] rand_coord();
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic void track_word(input touch_word_t w);
        logic [3:0]  count;
        logic        pressed;
        logic [11:0] px;
        logic [11:0] py;
        logic [31:0] elapsed;
        logic        emit;
        logic        ev;
        tsc_pkg::res_t r;
        count   = w.status[3:0] & tsc_pkg::COUNT_MASK;
        pressed = count != 4'd0 && count <= tsc_pkg::MAX_POINTS &&
                  w.x_high[7:6] != tsc_pkg::EVENT_LIFT;
        px      = {w.x_high[3:0], w.x_low};
        py      = {w.y_high[3:0], w.y_low};
        elapsed = w.now_ms - cap_start_ms;
        emit    = 1'b0;
        ev      = tsc_pkg::EV_POINT;
        r       = '0;
        if (w.kind == tsc_pkg::KIND_START)
        begin
            cap_phase    = CAP_WAIT_FIRST;
            cap_start_ms = w.now_ms;
            first_ms     = '0;
            first_x      = '0;
            first_y      = '0;
            last_x       = '0;
            last_y       = '0;
            release_run  = '0;
        end
        else if (cap_phase == CAP_WAIT_FIRST)
        begin
            if (elapsed >= {16'd0, window_ms})
            begin
                // no press in time: empty stroke
                cap_phase   = CAP_IDLE;
                r.event_res = tsc_pkg::EV_STROKE;
                stroke_q.push_back(r);
            end
            else if (w.read_ok && pressed)
            begin
                first_x     = px;
                first_y     = py;
                last_x      = px;
                last_y      = py;
                first_ms    = w.now_ms;
                release_run = '0;
                cap_phase   = CAP_TRACKING;
                emit        = 1'b1;
            end
        end
        else if (cap_phase == CAP_TRACKING)
        begin
            if (elapsed >= {16'd0, limit_ms})
            begin
                cap_phase = CAP_IDLE;
                emit      = 1'b1;
                ev        = tsc_pkg::EV_STROKE;
            end
            else if (w.read_ok)
            begin
                if (pressed)
                begin
                    last_x      = px;
                    last_y      = py;
                    release_run = '0;
                    emit        = 1'b1;
                end
                else
                begin
                    release_run = release_run + 2'd1;
                    if (release_run >= tsc_pkg::RELEASE_LIMIT)
                    begin
                        cap_phase   = CAP_IDLE;
                        release_run = '0;
                        emit        = 1'b1;
                        ev          = tsc_pkg::EV_STROKE;
                    end
                end
            end
        end
        if (emit)
        begin
            r.event_res    = ev;
            r.start_x      = first_x;
            r.start_y      = first_y;
            r.end_x        = last_x;
            r.end_y        = last_y;
            r.stroke_valid = 1'b1;
            if (ev == tsc_pkg::EV_POINT)
            begin
                r.point_x = last_x;
                r.point_y = last_y;
            end
            else
                r.duration_ms = w.now_ms - first_ms;
            stroke_q.push_back(r);
        end
    endfunction

    function automatic touch_word_t raw_word(input logic ok, input logic [7:0] st,
                                             input logic [7:0] xh, input logic [7:0] xl,
                                             input logic [7:0] yh, input logic [7:0] yl);
        touch_word_t w;
        w.kind    = tsc_pkg::KIND_POLL;
        w.read_ok = ok;
        w.status  = st;
        w.x_high  = xh;
        w.x_low   = xl;
        w.y_high  = yh;
        w.y_low   = yl;
        w.now_ms  = clock_ms;
        return w;
    endfunction

    function automatic touch_word_t poll_word(input logic ok, input logic pressed,
                                              input logic [11:0] x, input logic [11:0] y);
        logic [3:0] upper;
        logic [3:0] count;
        logic [1:0] flag;
        logic [1:0] junk2;
        logic [3:0] junk4;
        upper = 4'($urandom);
        junk2 = 2'($urandom);
        junk4 = 4'($urandom);
        flag  = 2'($urandom);
        if (pressed)
        begin
            count = 4'($urandom_range(1, 2));
            if (flag == tsc_pkg::EVENT_LIFT)
                flag = 2'd3;
        end
        else
        begin
            case ($urandom_range(0, 2))
                0: count = 4'd0;
                1: count = 4'($urandom_range(3, 15));
                default:
                begin
                    count = 4'($urandom_range(1, 2));
                    flag  = tsc_pkg::EVENT_LIFT;
                end
            endcase
        end
        return raw_word(ok, {upper, count}, {flag, junk2, x[11:8]}, x[7:0],
                        {junk4, y[11:8]}, y[7:0]);
    endfunction

    function automatic touch_word_t start_word();
        touch_word_t w;
        w        = {$urandom, $urandom, 10'($urandom)};
        w.kind   = tsc_pkg::KIND_START;
        w.now_ms = clock_ms;
        return w;
    endfunction

    function automatic touch_word_t noise_word();
        touch_word_t w;
        w        = {$urandom, $urandom, 10'($urandom)};
        w.now_ms = clock_ms;
        return w;
    endfunction

    function automatic void advance_clock(input int unsigned span);
        if ($urandom_range(0, 39) == 0)
            clock_ms += $urandom;
        else
            clock_ms += $urandom_range(0, span);
    endfunction

    task automatic send_word(input touch_word_t w);
        s_tvalid <= 1'b1;
        s_tuser  <= w.kind;
        s_tdata  <= {7'd0, w.now_ms, w.y_low, w.y_high, w.x_low, w.x_high, w.status,
                     w.read_ok};
        do @(posedge clk); while (s_tready !== 1'b1);
        track_word(w);
        words_sent++;
        if (tx_gap_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic reg_write(input logic [0:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic [0:0] idx, output logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_limits(input logic [15:0] win, input logic [15:0] lim);
        logic [31:0] rd;
        reg_write(tsc_pkg::REG_FIRST_WINDOW, win);
        reg_write(tsc_pkg::REG_CAPTURE_LIMIT, lim);
        window_ms = win;
        limit_ms  = lim;
        reg_read(tsc_pkg::REG_FIRST_WINDOW, rd);
        if (rd[15:0] !== win)
            flag_error($sformatf("first_window_ms readback: expected %0d got %0d", win, rd));
        reg_read(tsc_pkg::REG_CAPTURE_LIMIT, rd);
        if (rd[15:0] !== lim)
            flag_error($sformatf("capture_limit_ms readback: expected %0d got %0d", lim, rd));
    endtask

    // stop sending, wait for every expected word, then let queued polls drain
    task automatic settle();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (stroke_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (12) @(posedge clk);
        if (stroke_q.size() != 0)
        begin
            flag_error($sformatf("%0d expected result words never arrived", stroke_q.size()));
            stroke_q.delete();
        end
    endtask

    task automatic test_directed_cases();
        logic [31:0] t0;
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
        clock_ms    = 32'hFFFF_FE00;
        send_word(raw_word(1'b1, 8'h01, 8'h80, 8'h10, 8'h00, 8'h20));
        send_word(start_word());
        clock_ms += 32'h80;
        send_word(raw_word(1'b0, 8'h01, 8'h8F, 8'hFF, 8'h0F, 8'hFF));
        clock_ms += 32'h80;
        send_word(raw_word(1'b1, 8'h00, 8'h80, 8'h55, 8'h05, 8'h55));
        clock_ms += 32'h80;
        send_word(raw_word(1'b1, 8'h03, 8'h80, 8'h55, 8'h05, 8'h55));
        clock_ms += 32'h80;
        send_word(raw_word(1'b1, 8'h01, 8'h4A, 8'h55, 8'h05, 8'h55));
        // first point lands after the time counter wraps
        clock_ms += 32'h80;
        send_word(raw_word(1'b1, 8'hF2, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        clock_ms += 32'd100;
        send_word(raw_word(1'b1, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
        clock_ms += 32'd100;
        send_word(raw_word(1'b1, 8'h00, 8'h80, 8'h12, 8'h03, 8'h34));
        clock_ms += 32'd100;
        send_word(raw_word(1'b0, 8'h00, 8'h80, 8'h12, 8'h03, 8'h34));
        clock_ms += 32'd100;
        send_word(raw_word(1'b1, 8'h0F, 8'h80, 8'h12, 8'h03, 8'h34));
        clock_ms += 32'd100;
        send_word(raw_word(1'b1, 8'h02, 8'hB5, 8'hA5, 8'hF3, 8'h5A));
        clock_ms += 32'd100;
        send_word(raw_word(1'b1, 8'h00, 8'h85, 8'hA5, 8'h03, 8'h5A));
        clock_ms += 32'd100;
        send_word(raw_word(1'b1, 8'h01, 8'h45, 8'hA5, 8'h03, 8'h5A));
        clock_ms += 32'd100;
        send_word(raw_word(1'b1, 8'h03, 8'h85, 8'hA5, 8'h03, 8'h5A));
        send_word(raw_word(1'b1, 8'h01, 8'h80, 8'h10, 8'h00, 8'h20));
        // restart mid-capture, then first-window expiry on a failed read
        send_word(start_word());
        clock_ms += 32'd10;
        t0 = clock_ms;
        send_word(start_word());
        clock_ms = t0 + 32'd1999;
        send_word(raw_word(1'b1, 8'h00, 8'h80, 8'h10, 8'h00, 8'h20));
        clock_ms = t0 + 32'd2000;
        send_word(raw_word(1'b0, 8'h01, 8'h80, 8'h10, 8'h00, 8'h20));
        // capture limit reached on a failed read
        t0 = clock_ms;
        send_word(start_word());
        clock_ms = t0 + 32'd1999;
        send_word(raw_word(1'b1, 8'h01, 8'h81, 8'h23, 8'h04, 8'h56));
        clock_ms = t0 + 32'd4999;
        send_word(raw_word(1'b1, 8'h02, 8'h87, 8'h89, 8'h0A, 8'hBC));
        clock_ms = t0 + 32'd5000;
        send_word(raw_word(1'b0, 8'h02, 8'h87, 8'h89, 8'h0A, 8'hBC));
        send_word(raw_word(1'b1, 8'h02, 8'h87, 8'h89, 8'h0A, 8'hBC));
        settle();
    endtask

    task automatic test_limit_extremes();
        logic [31:0] t0;
        program_limits(16'd0, 16'd0);
        send_word(start_word());
        send_word(poll_word(1'b1, 1'b1, 12'h123, 12'h456));
        send_word(start_word());
        send_word(poll_word(1'b0, 1'b0, 12'h000, 12'hFFF));
        settle();
        program_limits(16'd1, 16'd0);
        send_word(start_word());
        send_word(poll_word(1'b1, 1'b1, 12'hFFF, 12'h000));
        send_word(poll_word(1'b1, 1'b1, 12'h321, 12'h654));
        settle();
        program_limits(16'hFFFF, 16'hFFFF);
        t0 = clock_ms;
        send_word(start_word());
        clock_ms = t0 + 32'd65534;
        send_word(poll_word(1'b1, 1'b1, 12'hABC, 12'hDEF));
        clock_ms = t0 + 32'd65535;
        send_word(poll_word(1'b1, 1'b0, 12'h000, 12'h000));
        t0 = clock_ms;
        send_word(start_word());
        clock_ms = t0 + 32'd65535;
        send_word(poll_word(1'b1, 1'b1, 12'h111, 12'h222));
        settle();
    endtask

    // result side held off while points keep coming: the block must stall its input
    task automatic test_output_hold();
        program_limits(16'hFFFF, 16'hFFFF);
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        send_word(start_word());
        hold_req = 1'b1;
        repeat (24)
        begin
            clock_ms += 32'd3;
            send_word(poll_word(1'b1, 1'b1, rand_coord(), rand_coord()));
        end
        settle();
    endtask

    task automatic random_stroke(input int unsigned span);
        int unsigned n;
        logic        ok;
        send_word(start_word());
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            advance_clock(span);
            ok = 1'($urandom);
            send_word(poll_word(ok, ok ? 1'b0 : 1'($urandom_range(0, 1)),
                                rand_coord(), rand_coord()));
        end
        advance_clock(span);
        send_word(poll_word(1'b1, 1'b1, rand_coord(), rand_coord()));
        n = $urandom_range(1, 16);
        repeat (n)
        begin
            advance_clock(span);
            case ($urandom_range(0, 9))
                0: send_word(noise_word());
                1: send_word(poll_word(1'b0, 1'($urandom_range(0, 1)),
                                       rand_coord(), rand_coord()));
                2, 3: send_word(poll_word(1'b1, 1'b0, rand_coord(), rand_coord()));
                default: send_word(poll_word(1'b1, 1'b1, rand_coord(), rand_coord()));
            endcase
        end
        if ($urandom_range(0, 1) == 1)
        begin
            repeat (3)
            begin
                advance_clock(span);
                if ($urandom_range(0, 5) == 0)
                    send_word(poll_word(1'b0, 1'b1, rand_coord(), rand_coord()));
                send_word(poll_word(1'b1, 1'b0, rand_coord(), rand_coord()));
            end
        end
    endtask

    task automatic test_random_strokes();
        logic [15:0] win;
        logic [15:0] lim;
        int unsigned span;
        int unsigned phase_end;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    win = 16'($urandom_range(100, 400));
                    lim = 16'($urandom_range(300, 1500));
                end
                1:
                begin
                    win = 16'($urandom_range(0, 20));
                    lim = 16'($urandom_range(0, 60));
                end
                2:
                begin
                    win = 16'($urandom);
                    lim = 16'($urandom);
                end
                3:
                begin
                    win = 16'hFFFF;
                    lim = 16'($urandom);
                end
                4:
                begin
                    win = 16'($urandom);
                    lim = 16'hFFFF;
                end
                default:
                begin
                    win = 16'($urandom_range(50, 2000));
                    lim = 16'($urandom_range(50, 5000));
                end
            endcase
            program_limits(win, lim);
            tx_gap_en   = (p != 2 && p != 5);
            rx_stall_en = (p != 2 && p != 5);
            clock_ms    = $urandom;
            span        = ((win > lim) ? win : lim) / 6 + 2;
            phase_end   = words_sent + 210;
            while (words_sent < phase_end)
                random_stroke(span);
            settle();
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_stall_en && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        tsc_pkg::res_t got;
        tsc_pkg::res_t want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                got.event_res = m_tuser;
                {got.duration_ms, got.stroke_valid, got.end_y, got.end_x, got.start_y,
                 got.start_x, got.point_y, got.point_x} = m_tdata[104:0];
                if (stroke_q.size() == 0)
                    flag_error($sformatf("unexpected result word: %s", show(got)));
                else
                begin
                    want = stroke_q.pop_front();
                    if (got.event_res !== want.event_res || got.point_x !== want.point_x ||
                        got.point_y !== want.point_y || got.start_x !== want.start_x ||
                        got.start_y !== want.start_y || got.end_x !== want.end_x ||
                        got.end_y !== want.end_y || got.stroke_valid !== want.stroke_valid ||
                        got.duration_ms !== want.duration_ms)
                        flag_error($sformatf("result mismatch: expected %s, got %s",
                                             show(want), show(got)));
                end
            end
        end
    end

    initial
    begin
        #1000000;
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_limit_extremes();
        test_output_hold();
        test_random_strokes();
        settle();
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/tsc_pkg.sv
src/tsc_front.sv
src/tsc_fifo.sv
src/tsc_back.sv
src/touch_stroke_capture_core.sv
sim/tb.sv
